[design/cmd_pkg.sv]
// package with shared types and constants for the message digest unit
`timescale 1ns / 1ps
package cmd_pkg;

	localparam logic [31:0] MIX_OFFSET = 32'd8191;
	localparam logic [7:0] PAD_BYTE = 8'hAA;
	localparam logic [31:0] LO_FLIP = 32'hFFFF0000;
	localparam logic [31:0] HI_FLIP = 32'h0000FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       no_data;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_PAD,
		ST_MIX_START,
		ST_MIX_WAIT,
		ST_COMBINE,
		ST_OUT
	} ctrl_state_t;

	// source selects for the mixer input
	typedef enum logic [1:0] {
		MSRC_BLOCK,
		MSRC_T1,
		MSRC_T2
	} mix_src_t;

	typedef struct packed {
		logic       write_byte;
		logic [1:0] byte_sel;   // 0 input, 1 len hi, 2 len lo, 3 pad
		logic       count_len;
		logic       mix_start;
		mix_src_t   mix_src;
		logic       save_first;
		logic       save_t1;
		logic       save_chain;
		logic       clear_msg;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_wrap;     // the byte written completes a block
		logic pos_zero;
		logic mix_done;
		logic first_pending;
	} dp_status_t;

	localparam logic [1:0] BSEL_IN = 2'd0;
	localparam logic [1:0] BSEL_LEN_HI = 2'd1;
	localparam logic [1:0] BSEL_LEN_LO = 2'd2;
	localparam logic [1:0] BSEL_PAD = 2'd3;

endpackage

[design/cmd_mixer.sv]
// four-round block mixer, one multiply-xor per word, launched and combined in separate phases
`timescale 1ns / 1ps
module cmd_mixer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] blk_in,
	output logic         done,
	output logic [127:0] blk_out
);
	import cmd_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] na_q, nb_q, nc_q;
	logic [1:0] round_q;
	logic [2:0] step_q;   // 0..3 word within a round; multiply and combine are sequenced by phase_q
	logic busy_q;
	logic phase_q;        // 0 launch products, 1 combine
	logic [31:0] mx, my, p_q, q_q, mres, nw;

	always_comb begin
		case (step_q[1:0])
			2'd0: begin mx = a_q; my = b_q; end
			2'd1: begin mx = b_q; my = c_q; end
			2'd2: begin mx = c_q; my = d_q; end
			default: begin mx = d_q; my = a_q; end
		endcase
		mres = p_q ^ q_q;
		case (step_q[1:0])
			2'd0: nw = mres ^ b_q ^ c_q ^ d_q;
			2'd1: nw = mres ^ a_q ^ na_q;
			2'd2: nw = mres ^ b_q ^ nb_q;
			default: nw = mres ^ c_q ^ nc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
			round_q <= '0;
			phase_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				round_q <= '0;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						step_q <= '0;
						round_q <= round_q + 2'd1;
						if (round_q == 2'd3) begin
							busy_q <= 1'b0;
							done <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= blk_in[127:96];
			b_q <= blk_in[95:64];
			c_q <= blk_in[63:32];
			d_q <= blk_in[31:0];
		end else if (busy_q) begin
			if (!phase_q) begin
				p_q <= (mx ^ LO_FLIP) * (my ^ HI_FLIP);
				q_q <= ((mx ^ LO_FLIP) + MIX_OFFSET) * ((my ^ HI_FLIP) + MIX_OFFSET);
			end else begin
				case (step_q[1:0])
					2'd0: na_q <= nw;
					2'd1: nb_q <= nw;
					2'd2: nc_q <= nw;
					default: begin
						// byte-rotated write-back
						a_q <= {nw[7:0], na_q[31:8]};
						b_q <= {na_q[7:0], nc_q[31:8]};
						c_q <= {nc_q[7:0], nb_q[31:8]};
						d_q <= {nb_q[7:0], nw[31:8]};
					end
				endcase
			end
		end
	end

	assign blk_out = {a_q, b_q, c_q, d_q};

endmodule

[design/cmd_datapath.sv]
// datapath: block store, length, position, chain and mixer
`timescale 1ns / 1ps
module cmd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_pkg::in_item_t   in_item,
	input  cmd_pkg::dp_cmd_t    cmd,
	output cmd_pkg::dp_status_t status,
	output cmd_pkg::out_item_t  result
);
	import cmd_pkg::*;

	logic [7:0] store_q [16];
	logic [127:0] chain_q, blk_q, t1_q;
	logic [15:0] len_q;
	logic [3:0] pos_q;
	logic first_q;
	logic [7:0] wbyte;
	logic [127:0] mix_in, mix_out, cur_blk;
	logic mix_done;

	always_comb begin
		case (cmd.byte_sel)
			BSEL_IN: wbyte = in_item.data_byte;
			BSEL_LEN_HI: wbyte = len_q[15:8];
			BSEL_LEN_LO: wbyte = len_q[7:0];
			default: wbyte = PAD_BYTE;
		endcase
		for (int i = 0; i < 16; i++) begin
			cur_blk[127 - 8 * i -: 8] = store_q[i];
		end
		case (cmd.mix_src)
			MSRC_BLOCK: mix_in = cur_blk;
			MSRC_T1: mix_in = {chain_q[127:64], blk_q[127:64]};
			default: mix_in = {blk_q[63:0], chain_q[63:0]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			store_q[pos_q] <= wbyte;
		end
		if (cmd.save_first) begin
			blk_q <= mix_out;
		end
		if (cmd.save_t1) begin
			t1_q <= mix_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd.write_byte) begin
				pos_q <= pos_q + 4'd1;
			end
			if (cmd.count_len) begin
				len_q <= len_q + 16'd1;
			end
			if (cmd.save_first && first_q) begin
				chain_q <= mix_out;
				first_q <= 1'b0;
			end
			if (cmd.save_chain) begin
				chain_q <= t1_q ^ mix_out;
			end
			if (cmd.clear_msg) begin
				chain_q <= '0;
				len_q <= '0;
				pos_q <= '0;
				first_q <= 1'b1;
			end
		end
	end

	cmd_mixer u_mixer (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mix_start),
		.blk_in(mix_in),
		.done(mix_done),
		.blk_out(mix_out)
	);

	assign status.pos_wrap = (pos_q == 4'd15);
	assign status.pos_zero = (pos_q == 4'd0);
	assign status.mix_done = mix_done;
	assign status.first_pending = first_q;
	assign result.digest_high = chain_q[127:64];
	assign result.digest_low = chain_q[63:0];

endmodule

[design/cmd_ctrl.sv]
// controller state machine for the message digest unit
`timescale 1ns / 1ps
module cmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cmd_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	input  cmd_pkg::dp_status_t status,
	output cmd_pkg::dp_cmd_t    cmd
);
	import cmd_pkg::*;

	ctrl_state_t state_q, state_d;
	ctrl_state_t ret_q, ret_d;     // where to go after a block is absorbed
	mix_src_t src_q, src_d;        // which mix pass is running

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			src_q <= MSRC_BLOCK;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			src_q <= src_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		src_d = src_q;
		cmd = '0;
		cmd.mix_src = src_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ret_d = in_item.last ? ST_LEN_HI : ST_IDLE;
					if (!in_item.no_data) begin
						cmd.write_byte = 1'b1;
						cmd.byte_sel = BSEL_IN;
						cmd.count_len = 1'b1;
					end
					if (!in_item.no_data && status.pos_wrap) begin
						state_d = ST_MIX_START;
						src_d = MSRC_BLOCK;
					end else if (in_item.last) begin
						state_d = ST_LEN_HI;
					end
				end
			end
			ST_LEN_HI: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = BSEL_LEN_HI;
				ret_d = ST_LEN_LO;
				state_d = status.pos_wrap ? ST_MIX_START : ST_LEN_LO;
				src_d = MSRC_BLOCK;
			end
			ST_LEN_LO: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = BSEL_LEN_LO;
				ret_d = ST_OUT;
				src_d = MSRC_BLOCK;
				state_d = status.pos_wrap ? ST_MIX_START : ST_PAD;
				if (!status.pos_wrap) begin
					ret_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.write_byte = 1'b1;
				cmd.byte_sel = BSEL_PAD;
				if (status.pos_wrap) begin
					state_d = ST_MIX_START;
					src_d = MSRC_BLOCK;
					ret_d = ST_OUT;
				end
			end
			ST_MIX_START: begin
				cmd.mix_start = 1'b1;
				state_d = ST_MIX_WAIT;
			end
			ST_MIX_WAIT: begin
				if (status.mix_done) begin
					case (src_q)
						MSRC_BLOCK: begin
							cmd.save_first = 1'b1;
							if (status.first_pending) begin
								state_d = ret_q;
							end else begin
								src_d = MSRC_T1;
								state_d = ST_MIX_START;
							end
						end
						MSRC_T1: begin
							cmd.save_t1 = 1'b1;
							src_d = MSRC_T2;
							state_d = ST_MIX_START;
						end
						default: begin
							state_d = ST_COMBINE;
						end
					endcase
				end
			end
			ST_COMBINE: begin
				cmd.save_chain = 1'b1;
				state_d = ret_q;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.clear_msg = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/custom_128bit_message_digest_unit.sv]
// top level of the 128-bit message digest unit
//
// channel   direction  payload      transfer when
// in        input      in_item_t    in_valid && in_ready
// out       output     out_item_t   out_valid && out_ready
//
// a byte that does not complete a block needs no mix pass
// a completed block costs one mix pass, or three passes
// when chained, all run on the single shared multiply-xor unit
// the final item adds length and padding bytes at one per cycle, except while a filled block is mixed
// input is held off while a block is mixed, length and padding are written, or the digest waits to transfer
// reset clears chain, length and position; no clearing pass
`timescale 1ns / 1ps
module custom_128bit_message_digest_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cmd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cmd_pkg::out_item_t out_data
);
	import cmd_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	cmd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	cmd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_data),
		.cmd(cmd),
		.status(status),
		.result(out_data)
	);

endmodule
